[rtl/vpd_pkg.sv]
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared types and constants of the vector pair distance block: norm mode
// codes, field widths and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vpd_pkg;

   localparam int ELEM_W  = 16;
   localparam int DIFF_W  = 16;
   localparam int TERM_W  = 2 * DIFF_W;
   localparam int TOTAL_W = 42;
   localparam int DIST_W  = 27;

   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(67108864);

   // Start value of the root's trial bit: the largest even power of two
   // below 2^TOTAL_W.
   localparam logic [TOTAL_W-1:0] ROOT_BIT_INIT = TOTAL_W'(1) << (TOTAL_W - 2);

   localparam logic [1:0] MODE_L0   = 2'd0;
   localparam logic [1:0] MODE_L1   = 2'd1;
   localparam logic [1:0] MODE_L2   = 2'd2;
   localparam logic [1:0] MODE_LINF = 2'd3;

   typedef struct packed {
      logic       accept;
      logic [1:0] mode;
      logic       root_start;
      logic       root_step;
      logic       load;
   } vpd_cmd_type;

   typedef struct packed {
      logic last_folded;
      logic root_last;
   } vpd_status_type;

endpackage

[rtl/vpd_ctrl.sv]
// ----------------------------------------------------------------------------
// vpd_ctrl
// Sequencer of the vector pair distance block: holds the norm mode, gates
// the request channel, runs the square root steps and owns the response
// valid flag.
// ----------------------------------------------------------------------------
module vpd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_element,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_norm_mode,
   output logic                    csr_ready,
   output vpd_pkg::vpd_cmd_type    cmd,
   input  vpd_pkg::vpd_status_type status
);
   import vpd_pkg::*;

   typedef enum logic [4:0] {
      S_RUN   = 5'b00001,
      S_DRAIN = 5'b00010,
      S_SETUP = 5'b00100,
      S_ROOT  = 5'b01000,
      S_LOAD  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       load;

   assign req_ready = (state_ff == S_RUN);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid & req_ready;
   assign load      = (state_ff == S_LOAD) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_RUN: begin
            if (accept && req_last_element) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (status.last_folded) begin
               state_in = (mode_ff == MODE_L2) ? S_SETUP : S_LOAD;
            end
         end
         S_SETUP: state_in = S_ROOT;
         S_ROOT: begin
            if (status.root_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (load) begin
               state_in = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid) begin
         mode_in = csr_norm_mode;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cmd.accept     = accept;
      cmd.mode       = mode_ff;
      cmd.root_start = (state_ff == S_SETUP);
      cmd.root_step  = (state_ff == S_ROOT);
      cmd.load       = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         mode_ff      <= MODE_L2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/vpd_datapath.sv]
// ----------------------------------------------------------------------------
// vpd_datapath
// Absolute difference, term and accumulate pipeline, the bit-pair square
// root unit and the response register of the vector pair distance block.
// ----------------------------------------------------------------------------
module vpd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [vpd_pkg::ELEM_W-1:0]   req_first_element,
   input  logic signed [vpd_pkg::ELEM_W-1:0]   req_second_element,
   input  logic                                req_last_element,
   output logic        [vpd_pkg::DIST_W-1:0]   rsp_distance,
   input  vpd_pkg::vpd_cmd_type                cmd,
   output vpd_pkg::vpd_status_type             status
);
   import vpd_pkg::*;

   // Pipeline control.
   logic                 st1_valid_ff, st2_valid_ff;
   logic                 st1_last_ff, st2_last_ff;
   // Payload.
   logic [DIFF_W-1:0]    diff_ff, diff_in;
   logic [TERM_W-1:0]    term_ff, term_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [TOTAL_W-1:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0]   root_ff, root_in;
   logic [TOTAL_W-1:0]   bit_ff, bit_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;

   logic signed [ELEM_W:0] diff_wide;
   logic [ELEM_W:0]        diff_abs;
   logic [TOTAL_W:0]       sum_wide;
   logic [TOTAL_W:0]       trial;
   logic [TOTAL_W-1:0]     result;

   always_comb begin
      diff_wide = (ELEM_W+1)'(req_first_element) - (ELEM_W+1)'(req_second_element);
      diff_abs  = diff_wide[ELEM_W] ? (ELEM_W+1)'(-diff_wide) : diff_wide;
      diff_in   = diff_abs[DIFF_W-1:0];
   end

   always_comb begin
      case (cmd.mode)
         MODE_L0: term_in = {{(TERM_W-1){1'b0}}, (diff_ff != '0)};
         MODE_L1: term_in = {{(TERM_W-DIFF_W){1'b0}}, diff_ff};
         MODE_L2: term_in = TERM_W'(diff_ff) * TERM_W'(diff_ff);
         default: term_in = {{(TERM_W-DIFF_W){1'b0}}, diff_ff};
      endcase
   end

   // Accumulator: saturating sum, or running maximum in the Linf mode.
   always_comb begin
      sum_wide = {1'b0, total_ff} + {{(TOTAL_W+1-TERM_W){1'b0}}, term_ff};
      total_in = total_ff;
      if (cmd.load) begin
         total_in = '0;
      end else if (st2_valid_ff) begin
         if (cmd.mode == MODE_LINF) begin
            if ({{(TOTAL_W-TERM_W){1'b0}}, term_ff} > total_ff) begin
               total_in = {{(TOTAL_W-TERM_W){1'b0}}, term_ff};
            end
         end else begin
            total_in = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
         end
      end
   end

   // One bit of the root per cycle; the remainder is left in rem_ff.
   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.root_start) begin
         rem_in  = total_ff;
         root_in = '0;
         bit_in  = ROOT_BIT_INIT;
      end else if (cmd.root_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[TOTAL_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_comb begin
      if (cmd.mode == MODE_L2) begin
         result = (rem_ff > root_ff) ? root_ff + TOTAL_W'(1) : root_ff;
      end else begin
         result = total_ff;
      end
      dist_in = dist_ff;
      if (cmd.load) begin
         dist_in = (result > TOTAL_W'(DIST_MAX)) ? DIST_MAX : result[DIST_W-1:0];
      end
   end

   assign status.last_folded = st2_valid_ff & st2_last_ff;
   assign status.root_last   = cmd.root_step & bit_ff[0];
   assign rsp_distance       = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         st1_valid_ff <= cmd.accept;
         st2_valid_ff <= st1_valid_ff;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         diff_ff     <= diff_in;
         st1_last_ff <= req_last_element;
      end
      if (st1_valid_ff) begin
         term_ff     <= term_in;
         st2_last_ff <= st1_last_ff;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      dist_ff <= dist_in;
   end

endmodule

[rtl/vector_pair_distance.sv]
// ----------------------------------------------------------------------------
// vector_pair_distance
// Distance between two vectors streamed as signed Q8.8 element pairs, under
// an L0, L1, L2 or Linf norm chosen by the norm mode register.
// ----------------------------------------------------------------------------
//   channel  | direction | ports
//   ---------+-----------+--------------------------------------------------
//   req      | in        | req_valid/ready, first/second/last_element
//   rsp      | out       | rsp_valid/ready, rsp_distance
//   csr      | in        | csr_valid/ready, csr_norm_mode
//
// Element pairs are taken one per cycle until the pair marked last. That
// transaction then passes through the three-stage fold, in the L2 mode
// through the root (a setup step, then one bit per cycle over 21 steps),
// and through the response load. A result waiting on rsp does not stop the
// next vector; only the next load waits for it. Reset is synchronous; it
// clears the total and sets the mode to L2.
module vector_pair_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [vpd_pkg::ELEM_W-1:0]   req_first_element,
   input  logic signed [vpd_pkg::ELEM_W-1:0]   req_second_element,
   input  logic                                req_last_element,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [vpd_pkg::DIST_W-1:0]   rsp_distance,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [1:0]                   csr_norm_mode
);
   import vpd_pkg::*;

   vpd_cmd_type    cmd;
   vpd_status_type status;

   vpd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_element (req_last_element),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_valid        (csr_valid),
      .csr_norm_mode    (csr_norm_mode),
      .csr_ready        (csr_ready),
      .cmd              (cmd),
      .status           (status)
   );

   vpd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_first_element  (req_first_element),
      .req_second_element (req_second_element),
      .req_last_element   (req_last_element),
      .rsp_distance       (rsp_distance),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

[rtl/vpd_checker.sv]
// ----------------------------------------------------------------------------
// vpd_checker
// Port-level checks of the vector pair distance block, bound to the top.
// ----------------------------------------------------------------------------
module vpd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_last_element,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic        [vpd_pkg::DIST_W-1:0]   rsp_distance
);
   import vpd_pkg::*;

   // A response that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("response changed while stalled");

   // While a response is valid, the distance never exceeds its saturation value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance <= DIST_MAX)
      else $error("distance above saturation value");

   // The block drains after the last pair of a vector.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_element |=> !req_ready)
      else $error("request taken right after a last pair");

   // No response is valid yet in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind vector_pair_distance vpd_checker u_vpd_checker (.*);
